@@ hdl/iwd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwd_pkg
// Shared types, opcode table and helper functions for the instruction word
// decoder.
// ----------------------------------------------------------------------------
package iwd_pkg;

  localparam int NUM_INSN = 69;
  localparam logic [6:0] INSN_UNKNOWN = 7'd69;

  // instruction format classes
  typedef enum logic [3:0] {
    FM_NONE,
    FM_REG,
    FM_REGIMM,
    FM_IMM,
    FM_SINGLE,
    FM_SHIFT,
    FM_REL,
    FM_CRU,
    FM_SRCREG,
    FM_SRCCNT,
    FM_TWO
  } form_t;

  // control flow classes
  typedef enum logic [2:0] {
    FLOW_NONE,
    FLOW_HALT,
    FLOW_RETURN,
    FLOW_ICALL,
    FLOW_JUMP,
    FLOW_CALL,
    FLOW_CJUMP
  } flow_t;

  // addressing mode code that takes an extension word
  localparam logic [1:0] MODE_INDEXED = 2'd2;

  // special opcodes and flow masks
  localparam logic [15:0] OP_IDLE_HALT = 16'h0340;
  localparam logic [15:0] OP_RETURN    = 16'h0380;
  localparam logic [15:0] MASK_SINGLE  = 16'hFFC0;
  localparam logic [15:0] MASK_SRCREG  = 16'hFC00;
  localparam logic [15:0] MASK_BYTE    = 16'hFF00;
  localparam logic [15:0] MASK_TOP     = 16'hF000;
  localparam logic [15:0] OP_BLWP      = 16'h0400;
  localparam logic [15:0] OP_B         = 16'h0440;
  localparam logic [15:0] OP_BL        = 16'h0680;
  localparam logic [15:0] OP_XOP       = 16'h2C00;
  localparam logic [15:0] OP_JMP       = 16'h1000;
  localparam logic [3:0]  CRU_GROUP    = 4'hD;

  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] match;
    form_t       form;
  } entry_t;

  typedef struct packed {
    logic [6:0] id;
    form_t      form;
  } lookup_t;

  // decoded record
  typedef struct packed {
    logic [6:0]  insn_id;
    logic [1:0]  src_mode;
    logic [3:0]  src_reg;
    logic [1:0]  dst_mode;
    logic [3:0]  dst_reg;
    logic [4:0]  count;
    logic [15:0] first_ext;
    logic [15:0] second_ext;
    logic [7:0]  byte_field;
    logic [15:0] jump_target;
    flow_t       flow_class;
    logic [1:0]  length_words;
  } rec_t;

  // opcode table, first match in table order wins
  localparam entry_t OPTABLE [NUM_INSN] = '{
    '{16'hFFE0, 16'h0200, FM_REGIMM}, '{16'hFFE0, 16'h0220, FM_REGIMM},
    '{16'hFFE0, 16'h0240, FM_REGIMM}, '{16'hFFE0, 16'h0260, FM_REGIMM},
    '{16'hFFE0, 16'h0280, FM_REGIMM}, '{16'hFFE0, 16'h02A0, FM_REG},
    '{16'hFFE0, 16'h02C0, FM_REG},    '{16'hFFFF, 16'h02E0, FM_IMM},
    '{16'hFFFF, 16'h0300, FM_IMM},    '{16'hFFFF, 16'h0340, FM_NONE},
    '{16'hFFFF, 16'h0360, FM_NONE},   '{16'hFFFF, 16'h0380, FM_NONE},
    '{16'hFFFF, 16'h03A0, FM_NONE},   '{16'hFFFF, 16'h03C0, FM_NONE},
    '{16'hFFFF, 16'h03E0, FM_NONE},
    '{16'hFFC0, 16'h0400, FM_SINGLE}, '{16'hFFC0, 16'h0440, FM_SINGLE},
    '{16'hFFC0, 16'h0480, FM_SINGLE}, '{16'hFFC0, 16'h04C0, FM_SINGLE},
    '{16'hFFC0, 16'h0500, FM_SINGLE}, '{16'hFFC0, 16'h0540, FM_SINGLE},
    '{16'hFFC0, 16'h0580, FM_SINGLE}, '{16'hFFC0, 16'h05C0, FM_SINGLE},
    '{16'hFFC0, 16'h0600, FM_SINGLE}, '{16'hFFC0, 16'h0640, FM_SINGLE},
    '{16'hFFC0, 16'h0680, FM_SINGLE}, '{16'hFFC0, 16'h06C0, FM_SINGLE},
    '{16'hFFC0, 16'h0700, FM_SINGLE}, '{16'hFFC0, 16'h0740, FM_SINGLE},
    '{16'hFF00, 16'h0800, FM_SHIFT},  '{16'hFF00, 16'h0900, FM_SHIFT},
    '{16'hFF00, 16'h0A00, FM_SHIFT},  '{16'hFF00, 16'h0B00, FM_SHIFT},
    '{16'hFF00, 16'h1000, FM_REL},    '{16'hFF00, 16'h1100, FM_REL},
    '{16'hFF00, 16'h1200, FM_REL},    '{16'hFF00, 16'h1300, FM_REL},
    '{16'hFF00, 16'h1400, FM_REL},    '{16'hFF00, 16'h1500, FM_REL},
    '{16'hFF00, 16'h1600, FM_REL},    '{16'hFF00, 16'h1700, FM_REL},
    '{16'hFF00, 16'h1800, FM_REL},    '{16'hFF00, 16'h1900, FM_REL},
    '{16'hFF00, 16'h1A00, FM_REL},    '{16'hFF00, 16'h1B00, FM_REL},
    '{16'hFF00, 16'h1C00, FM_REL},
    '{16'hFF00, 16'h1D00, FM_CRU},    '{16'hFF00, 16'h1E00, FM_CRU},
    '{16'hFF00, 16'h1F00, FM_CRU},
    '{16'hFC00, 16'h2000, FM_SRCREG}, '{16'hFC00, 16'h2400, FM_SRCREG},
    '{16'hFC00, 16'h2800, FM_SRCREG}, '{16'hFC00, 16'h2C00, FM_SRCREG},
    '{16'hFC00, 16'h3000, FM_SRCCNT}, '{16'hFC00, 16'h3400, FM_SRCCNT},
    '{16'hFC00, 16'h3800, FM_SRCREG}, '{16'hFC00, 16'h3C00, FM_SRCREG},
    '{16'hF000, 16'h4000, FM_TWO},    '{16'hF000, 16'h5000, FM_TWO},
    '{16'hF000, 16'h6000, FM_TWO},    '{16'hF000, 16'h7000, FM_TWO},
    '{16'hF000, 16'h8000, FM_TWO},    '{16'hF000, 16'h9000, FM_TWO},
    '{16'hF000, 16'hA000, FM_TWO},    '{16'hF000, 16'hB000, FM_TWO},
    '{16'hF000, 16'hC000, FM_TWO},    '{16'hF000, 16'hD000, FM_TWO},
    '{16'hF000, 16'hE000, FM_TWO},    '{16'hF000, 16'hF000, FM_TWO}
  };

  // parallel compare against every entry, lowest index wins
  function automatic lookup_t insn_lookup(input logic [15:0] op);
    lookup_t res;
    res.id   = INSN_UNKNOWN;
    res.form = FM_NONE;
    for (int i = NUM_INSN - 1; i >= 0; i--) begin
      if ((op & OPTABLE[i].mask) == OPTABLE[i].match) begin
        res.id   = 7'(i);
        res.form = OPTABLE[i].form;
      end
    end
    return res;
  endfunction

  // forms that carry a general source operand in bits 5..0
  function automatic logic has_src_mode(input form_t fm);
    return (fm == FM_SINGLE) || (fm == FM_SRCREG) || (fm == FM_SRCCNT) ||
           (fm == FM_TWO);
  endfunction

endpackage
`default_nettype wire

@@ hdl/iwd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwd_decode
// Opcode table match and field extraction for one instruction; also reports
// which extension words the opcode asks for.
// ----------------------------------------------------------------------------
module iwd_decode
  import iwd_pkg::*;
(
  input  logic [15:0] op,
  input  logic [15:0] op_addr,
  input  logic [15:0] first_ext,
  input  logic [15:0] second_ext,
  input  logic [1:0]  length_words,
  output logic        need_src,
  output logic        need_dst,
  output rec_t        rec
);

  lookup_t    lk;
  logic       known;
  logic [3:0] cnt_field;
  logic [15:0] disp2;

  assign lk        = insn_lookup(op);
  assign known     = (lk.id != INSN_UNKNOWN);
  assign cnt_field = op[9:6];
  // signed displacement in words, scaled to bytes
  assign disp2     = {{7{op[7]}}, op[7:0], 1'b0};

  // extension word roles
  assign need_src = (lk.form == FM_REGIMM) || (lk.form == FM_IMM) ||
                    (has_src_mode(lk.form) && (op[5:4] == MODE_INDEXED));
  assign need_dst = (lk.form == FM_TWO) && (op[11:10] == MODE_INDEXED);

  // field extraction
  always_comb begin
    rec              = '0;
    rec.insn_id      = lk.id;
    rec.length_words = length_words;
    if (known) begin
      if (has_src_mode(lk.form)) begin
        rec.src_mode = op[5:4];
        rec.src_reg  = op[3:0];
      end
      if ((lk.form == FM_REG) || (lk.form == FM_REGIMM) || (lk.form == FM_SHIFT)) begin
        rec.src_reg = op[3:0];
      end
      if ((lk.form == FM_SRCREG) || (lk.form == FM_SRCCNT) || (lk.form == FM_TWO)) begin
        rec.dst_reg = op[9:6];
      end
      if (lk.form == FM_TWO) begin
        rec.dst_mode = op[11:10];
      end
      if (lk.form == FM_SHIFT) begin
        rec.count = {1'b0, op[7:4]};
      end
      if (lk.form == FM_SRCCNT) begin
        rec.count = (cnt_field == 4'd0) ? 5'd16 : {1'b0, cnt_field};
      end
      rec.first_ext  = first_ext;
      rec.second_ext = second_ext;
      if ((lk.form == FM_REL) || (lk.form == FM_CRU)) begin
        rec.byte_field = op[7:0];
      end
      if (lk.form == FM_REL) begin
        rec.jump_target = op_addr + 16'd2 + disp2;
      end
      // flow class, order decides
      priority if (op == OP_IDLE_HALT) begin
        rec.flow_class = FLOW_HALT;
      end else if (op == OP_RETURN) begin
        rec.flow_class = FLOW_RETURN;
      end else if (((op & MASK_SINGLE) == OP_BLWP) || ((op & MASK_SRCREG) == OP_XOP)) begin
        rec.flow_class = FLOW_ICALL;
      end else if ((op & MASK_SINGLE) == OP_B) begin
        rec.flow_class = FLOW_JUMP;
      end else if ((op & MASK_SINGLE) == OP_BL) begin
        rec.flow_class = FLOW_CALL;
      end else if ((op & MASK_BYTE) == OP_JMP) begin
        rec.flow_class = FLOW_JUMP;
      end else if (((op & MASK_TOP) == OP_JMP) && (op[11:8] < CRU_GROUP)) begin
        rec.flow_class = FLOW_CJUMP;
      end else begin
        rec.flow_class = FLOW_NONE;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/instruction_word_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// instruction_word_decoder_core
// Decodes a stream of program words into one record per instruction.
// ----------------------------------------------------------------------------
// Program words enter one per cycle, while in_ready is high, with their byte
// address. Each word lands in an input register; from there it is either
// taken as an opcode, matched against the opcode table, or taken as an
// immediate or extension word of the opcode held from earlier. A record goes
// to the output register when the last word of an instruction leaves the
// input register. The block takes one word per cycle unless the output
// stalls; the figure is set by the single table compare between the input
// register and the result register. The output register only blocks input
// when a record is waiting and out_ready is low.
// ----------------------------------------------------------------------------
module instruction_word_decoder_core
  import iwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_word,
  input  logic [15:0] in_word_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_insn_id,
  output logic [1:0]  out_src_mode,
  output logic [3:0]  out_src_reg,
  output logic [1:0]  out_dst_mode,
  output logic [3:0]  out_dst_reg,
  output logic [4:0]  out_count,
  output logic [15:0] out_first_ext,
  output logic [15:0] out_second_ext,
  output logic [7:0]  out_byte_field,
  output logic [15:0] out_jump_target,
  output logic [2:0]  out_flow_class,
  output logic [1:0]  out_length_words
);

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] s1_word_r;
  logic [15:0] s1_addr_r;

  // instruction assembly state
  logic [1:0]  need_r, need_nxt;
  logic        seen_r, seen_nxt;
  logic        pend_src_r, pend_src_nxt;
  logic        pend_dst_r, pend_dst_nxt;
  logic [15:0] pend_op_r, pend_op_nxt;
  logic [15:0] pend_addr_r, pend_addr_nxt;
  logic [15:0] held_r, held_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  rec_t        out_rec_r, out_rec_nxt;

  logic        out_free;
  logic        s2_fire;
  logic        emit;
  logic [15:0] dec_op, dec_addr, dec_first, dec_second;
  logic [1:0]  dec_len;
  logic        dec_src, dec_dst;
  logic [15:0] e0, e1;
  rec_t        dec_rec;

  assign out_free = !out_valid_r || out_ready;
  assign s2_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // input register load
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_word;
      s1_addr_r <= in_word_addr;
    end
  end

  // extension words in arrival order
  assign e0 = seen_r ? held_r : s1_word_r;
  assign e1 = seen_r ? s1_word_r : 16'd0;

  // decoder operand selection
  always_comb begin
    dec_op     = s1_word_r;
    dec_addr   = s1_addr_r;
    dec_first  = 16'd0;
    dec_second = 16'd0;
    dec_len    = 2'd1;
    if (need_r != 2'd0) begin
      dec_op   = pend_op_r;
      dec_addr = pend_addr_r;
      if (pend_src_r && pend_dst_r) begin
        dec_first  = e0;
        dec_second = e1;
        dec_len    = 2'd3;
      end else if (pend_src_r) begin
        dec_first = e0;
        dec_len   = 2'd2;
      end else begin
        dec_second = e0;
        dec_len    = 2'd2;
      end
    end
  end

  iwd_decode u_decode (
    .op           (dec_op),
    .op_addr      (dec_addr),
    .first_ext    (dec_first),
    .second_ext   (dec_second),
    .length_words (dec_len),
    .need_src     (dec_src),
    .need_dst     (dec_dst),
    .rec          (dec_rec)
  );

  // word sequencing
  always_comb begin
    need_nxt      = need_r;
    seen_nxt      = seen_r;
    pend_src_nxt  = pend_src_r;
    pend_dst_nxt  = pend_dst_r;
    pend_op_nxt   = pend_op_r;
    pend_addr_nxt = pend_addr_r;
    held_nxt      = held_r;
    emit          = 1'b0;
    if (s2_fire) begin
      unique case (need_r)
        2'd0: begin
          if (!dec_src && !dec_dst) begin
            emit = 1'b1;
          end else begin
            pend_op_nxt   = s1_word_r;
            pend_addr_nxt = s1_addr_r;
            pend_src_nxt  = dec_src;
            pend_dst_nxt  = dec_dst;
            seen_nxt      = 1'b0;
            held_nxt      = 16'd0;
            need_nxt      = {1'b0, dec_src} + {1'b0, dec_dst};
          end
        end
        2'd1: begin
          emit     = 1'b1;
          need_nxt = 2'd0;
          seen_nxt = 1'b0;
          held_nxt = 16'd0;
        end
        default: begin
          held_nxt = s1_word_r;
          seen_nxt = 1'b1;
          need_nxt = 2'd1;
        end
      endcase
    end
  end

  // output register load
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rec_nxt   = out_rec_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_rec_nxt   = dec_rec;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      need_r      <= 2'd0;
      seen_r      <= 1'b0;
      pend_src_r  <= 1'b0;
      pend_dst_r  <= 1'b0;
      pend_op_r   <= 16'd0;
      pend_addr_r <= 16'd0;
      held_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      need_r      <= need_nxt;
      seen_r      <= seen_nxt;
      pend_src_r  <= pend_src_nxt;
      pend_dst_r  <= pend_dst_nxt;
      pend_op_r   <= pend_op_nxt;
      pend_addr_r <= pend_addr_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
  end

  // result ports
  assign out_valid        = out_valid_r;
  assign out_insn_id      = out_rec_r.insn_id;
  assign out_src_mode     = out_rec_r.src_mode;
  assign out_src_reg      = out_rec_r.src_reg;
  assign out_dst_mode     = out_rec_r.dst_mode;
  assign out_dst_reg      = out_rec_r.dst_reg;
  assign out_count        = out_rec_r.count;
  assign out_first_ext    = out_rec_r.first_ext;
  assign out_second_ext   = out_rec_r.second_ext;
  assign out_byte_field   = out_rec_r.byte_field;
  assign out_jump_target  = out_rec_r.jump_target;
  assign out_flow_class   = out_rec_r.flow_class;
  assign out_length_words = out_rec_r.length_words;

endmodule
`default_nettype wire

@@ hdl/iwd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module iwd_checker
  import iwd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [15:0] in_word,
  input wire logic [15:0] in_word_addr,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  out_insn_id,
  input wire logic [1:0]  out_src_mode,
  input wire logic [3:0]  out_src_reg,
  input wire logic [1:0]  out_dst_mode,
  input wire logic [3:0]  out_dst_reg,
  input wire logic [4:0]  out_count,
  input wire logic [15:0] out_first_ext,
  input wire logic [15:0] out_second_ext,
  input wire logic [7:0]  out_byte_field,
  input wire logic [15:0] out_jump_target,
  input wire logic [2:0]  out_flow_class,
  input wire logic [1:0]  out_length_words
);

  // a stalled transaction holds its record
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_insn_id) &&
      $stable(out_first_ext) && $stable(out_second_ext) && $stable(out_length_words))
    else $error("result transaction changed while stalled");

  // reset leaves no record pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // unknown opcodes are one word with nothing decoded
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_insn_id == INSN_UNKNOWN) |->
      (out_length_words == 2'd1) && (out_flow_class == FLOW_NONE) &&
      (out_first_ext == 16'd0) && (out_src_reg == 4'd0))
    else $error("unknown opcode record not clean");

  // a single-word instruction carries no extension words
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_length_words == 2'd1) |->
      (out_first_ext == 16'd0) && (out_second_ext == 16'd0))
    else $error("extension word on single-word instruction");

  // record id and length within range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length_words != 2'd0) && (out_insn_id <= INSN_UNKNOWN) &&
      (out_count <= 5'd16))
    else $error("record field out of range");

endmodule

bind instruction_word_decoder_core iwd_checker u_iwd_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the instruction word decoder core. A queue of
// program words feeds a valid/ready driver. A word-by-word decoder model turns
// every accepted word into expected records, and a monitor checks each
// record field by field. Both sides idle at random, and the output side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import iwd_pkg::*;

  // one program word and its byte address
  typedef struct packed {
    logic [15:0] word;
    logic [15:0] addr;
  } prog_word_t;

  // one decoded instruction record
  typedef struct packed {
    logic [6:0]  insn_id;
    logic [1:0]  src_mode;
    logic [3:0]  src_reg;
    logic [1:0]  dst_mode;
    logic [3:0]  dst_reg;
    logic [4:0]  count;
    logic [15:0] first_ext;
    logic [15:0] second_ext;
    logic [7:0]  byte_field;
    logic [15:0] jump_target;
    logic [2:0]  flow_class;
    logic [1:0]  length_words;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_word = '0;
  logic [15:0] in_word_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_insn_id;
  logic [1:0]  out_src_mode;
  logic [3:0]  out_src_reg;
  logic [1:0]  out_dst_mode;
  logic [3:0]  out_dst_reg;
  logic [4:0]  out_count;
  logic [15:0] out_first_ext;
  logic [15:0] out_second_ext;
  logic [7:0]  out_byte_field;
  logic [15:0] out_jump_target;
  logic [2:0]  out_flow_class;
  logic [1:0]  out_length_words;

  instruction_word_decoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_word          (in_word),
    .in_word_addr     (in_word_addr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_insn_id      (out_insn_id),
    .out_src_mode     (out_src_mode),
    .out_src_reg      (out_src_reg),
    .out_dst_mode     (out_dst_mode),
    .out_dst_reg      (out_dst_reg),
    .out_count        (out_count),
    .out_first_ext    (out_first_ext),
    .out_second_ext   (out_second_ext),
    .out_byte_field   (out_byte_field),
    .out_jump_target  (out_jump_target),
    .out_flow_class   (out_flow_class),
    .out_length_words (out_length_words)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  prog_word_t  prog_q[$];
  decoded_t    decoded_q[$];
  int          total_words = 0;
  int          words_taken = 0;
  int          records_seen = 0;
  int          fail_cnt = 0;
  int          cyc = 0;
  logic        in_taken = 1'b0;
  int          send_gap = 0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;
  logic        quiet;

  // decoder model state
  logic [15:0] pend_op = '0;
  logic [15:0] pend_addr = '0;
  logic [15:0] held_ext = '0;
  logic [1:0]  words_needed = '0;
  logic [1:0]  exts_seen = '0;

  decoded_t    want_rec;
  decoded_t    got_rec;

  // periodic stretches with no idling on either side
  always @(posedge clk) cyc <= cyc + 1;
  assign quiet = (cyc[8:7] == 2'b00);

  // instruction number and format of an opcode
  function automatic void classify(input logic [15:0] op, output logic [6:0] id,
                                   output form_t fm);
    id = INSN_UNKNOWN;
    fm = FM_NONE;
    if (op[15:12] >= 4'h4) begin
      id = 7'd53 + 7'(op[15:12]);
      fm = FM_TWO;
    end else if (op[15:13] == 3'b001) begin
      id = 7'd49 + 7'(op[12:10]);
      fm = (op[12:10] == 3'd4 || op[12:10] == 3'd5) ? FM_SRCCNT : FM_SRCREG;
    end else if (op[15:12] == 4'h1) begin
      id = 7'd33 + 7'(op[11:8]);
      fm = (op[11:8] >= CRU_GROUP) ? FM_CRU : FM_REL;
    end else if (op[15:10] == 6'b000010) begin
      id = 7'd29 + 7'(op[9:8]);
      fm = FM_SHIFT;
    end else if (op[15:11] == 5'b00000 && op[10]) begin
      // single-operand group, 14 opcodes from bits 10..6
      if (op[10:6] <= 5'd29) begin
        id = 7'(op[10:6]) - 7'd1;
        fm = FM_SINGLE;
      end
    end else if (op[15:10] == 6'b000000 && op[9]) begin
      // register and immediate group, bits 9..5
      if (op[9:5] <= 5'd22) begin
        id = 7'(op[9:5]) - 7'd16;
        fm = (op[9:5] <= 5'd20) ? FM_REGIMM : FM_REG;
      end else if (op[4:0] == 5'd0) begin
        if (op[9:5] == 5'd23 || op[9:5] == 5'd24) begin
          id = 7'(op[9:5]) - 7'd16;
          fm = FM_IMM;
        end else if (op[9:5] >= 5'd26) begin
          id = 7'(op[9:5]) - 7'd17;
          fm = FM_NONE;
        end
      end
    end
  endfunction

  function automatic logic general_src(input form_t fm);
    return fm == FM_SINGLE || fm == FM_SRCREG || fm == FM_SRCCNT || fm == FM_TWO;
  endfunction

  // which extension words an opcode pulls in
  function automatic void ext_roles(input logic [15:0] op, output logic src_x,
                                    output logic dst_x);
    logic [6:0] id;
    form_t      fm;
    classify(op, id, fm);
    src_x = fm == FM_REGIMM || fm == FM_IMM ||
            (general_src(fm) && op[5:4] == MODE_INDEXED);
    dst_x = fm == FM_TWO && op[11:10] == MODE_INDEXED;
  endfunction

  function automatic flow_t flow_of(input logic [15:0] op);
    if (op == OP_IDLE_HALT) return FLOW_HALT;
    if (op == OP_RETURN) return FLOW_RETURN;
    if ((op & MASK_SINGLE) == OP_BLWP || (op & MASK_SRCREG) == OP_XOP) return FLOW_ICALL;
    if ((op & MASK_SINGLE) == OP_B) return FLOW_JUMP;
    if ((op & MASK_SINGLE) == OP_BL) return FLOW_CALL;
    if ((op & MASK_BYTE) == OP_JMP) return FLOW_JUMP;
    if (op[15:12] == 4'h1 && op[11:8] < CRU_GROUP) return FLOW_CJUMP;
    return FLOW_NONE;
  endfunction

  // full record of a completed instruction
  function automatic decoded_t build_record(input logic [15:0] op, addr, e0, e1,
                                            input logic [1:0] len);
    decoded_t   r;
    logic [6:0] id;
    form_t      fm;
    r = '0;
    classify(op, id, fm);
    r.insn_id = id;
    r.length_words = len;
    if (id != INSN_UNKNOWN) begin
      if (general_src(fm)) begin
        r.src_mode = op[5:4];
        r.src_reg = op[3:0];
      end
      if (fm == FM_REG || fm == FM_REGIMM || fm == FM_SHIFT) r.src_reg = op[3:0];
      if (fm == FM_SRCREG || fm == FM_SRCCNT || fm == FM_TWO) r.dst_reg = op[9:6];
      if (fm == FM_TWO) r.dst_mode = op[11:10];
      if (fm == FM_SHIFT) r.count = {1'b0, op[7:4]};
      if (fm == FM_SRCCNT) r.count = (op[9:6] == 4'd0) ? 5'd16 : {1'b0, op[9:6]};
      r.first_ext = e0;
      r.second_ext = e1;
      if (fm == FM_REL || fm == FM_CRU) r.byte_field = op[7:0];
      if (fm == FM_REL) r.jump_target = addr + 16'd2 + {{7{op[7]}}, op[7:0], 1'b0};
      r.flow_class = flow_of(op);
    end
    return r;
  endfunction

  // advance the decoder by one accepted word
  task automatic decode_word(input logic [15:0] w, input logic [15:0] a);
    logic        sx, dx;
    logic [15:0] e0, e1;
    if (words_needed == 2'd0) begin
      ext_roles(w, sx, dx);
      if (!sx && !dx) begin
        decoded_q.push_back(build_record(w, a, 16'h0, 16'h0, 2'd1));
      end else begin
        pend_op = w;
        pend_addr = a;
        held_ext = '0;
        exts_seen = '0;
        words_needed = 2'(sx) + 2'(dx);
      end
    end else if (words_needed >= 2'd2) begin
      held_ext = w;
      exts_seen = 2'd1;
      words_needed = 2'd1;
    end else begin
      if (exts_seen == 2'd1) begin
        e0 = held_ext;
        e1 = w;
      end else begin
        e0 = w;
        e1 = '0;
      end
      ext_roles(pend_op, sx, dx);
      if (sx && dx) decoded_q.push_back(build_record(pend_op, pend_addr, e0, e1, 2'd3));
      else if (sx) decoded_q.push_back(build_record(pend_op, pend_addr, e0, 16'h0, 2'd2));
      else decoded_q.push_back(build_record(pend_op, pend_addr, 16'h0, e0, 2'd2));
      words_needed = '0;
      exts_seen = '0;
      held_ext = '0;
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_ext();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // queue an opcode and whatever extension words it takes
  task automatic queue_insn(input logic [15:0] op, input logic [15:0] addr,
                            input logic [15:0] e0, input logic [15:0] e1);
    logic sx, dx;
    ext_roles(op, sx, dx);
    prog_q.push_back('{op, addr});
    if (sx || dx) prog_q.push_back('{e0, addr + 16'd2});
    if (sx && dx) prog_q.push_back('{e1, addr + 16'd4});
    total_words = total_words + 1 + int'(sx) + int'(dx);
  endtask

  // opcode for a chosen instruction number, unknown words for the top value
  function automatic logic [15:0] pick_opcode(input int id);
    logic [15:0] raw;
    raw = 16'($urandom);
    if (id < NUM_INSN) return OPTABLE[id].match | (raw & ~OPTABLE[id].mask);
    case ($urandom_range(0, 3))
      0: return {7'd0, raw[8:0]};
      1: return 16'h0320;
      2: return {9'b0000_0111_1, raw[6:0]};
      default: return {6'b000011, raw[9:0]};
    endcase
  endfunction

  // stimulus and end of test
  initial begin : stimulus
    logic [15:0] pc;
    logic [15:0] op;
    // directed: field extremes, every format but FM_REG, flow classes, wrapping jumps
    queue_insn(16'h0000, 16'h0000, 16'h0, 16'h0);
    queue_insn(16'hFFFF, 16'hFFFE, 16'h0, 16'h0);
    queue_insn(16'h020F, 16'h0100, 16'hFFFF, 16'h0);
    queue_insn(16'h0340, 16'h0104, 16'h0, 16'h0);
    queue_insn(16'h0380, 16'h0106, 16'h0, 16'h0);
    queue_insn(16'h0420, 16'h0108, 16'h0000, 16'h0);
    queue_insn(16'h0680, 16'h010C, 16'h0, 16'h0);
    queue_insn(16'h045B, 16'h010E, 16'h0, 16'h0);
    queue_insn(16'h2C00, 16'h0110, 16'h0, 16'h0);
    queue_insn(16'h1080, 16'h0000, 16'h0, 16'h0);
    queue_insn(16'h1C7F, 16'hFFFE, 16'h0, 16'h0);
    queue_insn(16'h1DFF, 16'h8000, 16'h0, 16'h0);
    queue_insn(16'h0800, 16'h8002, 16'h0, 16'h0);
    queue_insn(16'h3000, 16'h8004, 16'h0, 16'h0);
    queue_insn(16'h0320, 16'h8006, 16'h0, 16'h0);
    queue_insn(16'hA825, 16'h8008, 16'h1234, 16'hFFFF);
    queue_insn(16'hA805, 16'h800E, 16'h8001, 16'h0);
    queue_insn(16'h02E0, 16'h8012, 16'h0000, 16'h0);
    queue_insn(16'h3FFF, 16'h8016, 16'h0, 16'h0);
    // random instruction stream, addresses advance by twice the running word count and sometimes jump
    pc = 16'($urandom);
    while (total_words < 1300) begin
      if ($urandom_range(0, 9) == 0) pc = 16'($urandom);
      if ($urandom_range(0, 4) == 0) op = 16'($urandom);
      else op = pick_opcode($urandom_range(0, NUM_INSN));
      queue_insn(op, pc, rand_ext(), rand_ext());
      pc = 16'(total_words * 2) + pc;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_taken < total_words) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  // input side: record each accepted transaction and predict its records
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      decode_word(in_word, in_word_addr);
      words_taken++;
    end
  end

  // word driver, changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (prog_q.size() != 0) begin
        in_valid <= 1'b1;
        in_word <= prog_q[0].word;
        in_word_addr <= prog_q[0].addr;
        prog_q.pop_front();
        send_gap <= quiet ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && records_seen >= 150) begin
      out_ready <= 1'b0;
      hold_left <= 300;
      long_hold_done <= 1'b1;
    end else if (quiet || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_left <= idle_len();
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch on record %0d, %s: expected %0h, got %0h",
                 records_seen, name, want, got);
    end
  endtask

  // record monitor, compares each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      records_seen++;
      got_rec = '{out_insn_id, out_src_mode, out_src_reg, out_dst_mode, out_dst_reg,
                  out_count, out_first_ext, out_second_ext, out_byte_field,
                  out_jump_target, out_flow_class, out_length_words};
      if (decoded_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected record %0d: insn_id %0d", records_seen, out_insn_id);
      end else begin
        want_rec = decoded_q.pop_front();
        check_field("insn_id", 16'(want_rec.insn_id), 16'(got_rec.insn_id));
        check_field("src_mode", 16'(want_rec.src_mode), 16'(got_rec.src_mode));
        check_field("src_reg", 16'(want_rec.src_reg), 16'(got_rec.src_reg));
        check_field("dst_mode", 16'(want_rec.dst_mode), 16'(got_rec.dst_mode));
        check_field("dst_reg", 16'(want_rec.dst_reg), 16'(got_rec.dst_reg));
        check_field("count", 16'(want_rec.count), 16'(got_rec.count));
        check_field("first_ext", want_rec.first_ext, got_rec.first_ext);
        check_field("second_ext", want_rec.second_ext, got_rec.second_ext);
        check_field("byte_field", 16'(want_rec.byte_field), 16'(got_rec.byte_field));
        check_field("jump_target", want_rec.jump_target, got_rec.jump_target);
        check_field("flow_class", 16'(want_rec.flow_class), 16'(got_rec.flow_class));
        check_field("length_words", 16'(want_rec.length_words),
                    16'(got_rec.length_words));
      end
    end
  end

endmodule
